// ===== hdl/lbm_d2q9_bgk_cell_update_assert.svh =====
// Assertion macros used by the cell update checker.
`ifndef LBM_D2Q9_BGK_CELL_UPDATE_ASSERT_SVH
`define LBM_D2Q9_BGK_CELL_UPDATE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define LBMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LBMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lbmc_pkg.sv =====
// Types, constants and helpers of the D2Q9 BGK cell update.
package lbmc_pkg;

  localparam int WordW     = 32;
  localparam int NumDir    = 9;
  localparam int FracBits  = 28;
  localparam int RelaxW    = 31;
  localparam int RelaxFrac = 30;
  localparam logic [RelaxW-1:0] RelaxReset = 31'd1994325120;

  // density / momentum sums and divider widths
  localparam int SumW     = WordW + 4;
  localparam int MagW     = WordW + 2;
  localparam int RhoW     = WordW + 3;
  localparam int NumW     = MagW + FracBits;
  localparam int QuoW     = WordW - 1;
  localparam int DivSteps = QuoW + 1;

  // equilibrium widths
  localparam int ProdW = 2 * WordW;
  localparam int SqW   = ProdW - FracBits;
  localparam int CuW   = WordW + 2;
  localparam int PW    = (SqW + 6 > CuW + 4) ? SqW + 6 : CuW + 4;
  localparam int TW    = ProdW - FracBits;
  localparam int YW    = TW + 2;
  localparam int RecipW = YW - 3;
  localparam int QW    = YW - 3;
  localparam int LoW   = YW / 2;
  localparam int HiW   = YW - LoW;
  localparam int AccW  = YW + RecipW + 1;
  localparam logic [RecipW-1:0] Recip = RecipW'((64'd1 << YW) / 64'd9);

  // relaxation widths
  localparam int DiffW    = WordW + 1;
  localparam int RelProdW = DiffW + WordW;
  localparam int SatInW   = ProdW + 16;

  typedef logic signed [WordW-1:0] word_t;
  typedef word_t [NumDir-1:0] dist_vec_t;

  localparam word_t WordMax = 32'sh7FFF_FFFF;
  localparam word_t WordMin = 32'sh8000_0000;
  localparam logic [WordW-1:0] VCap = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    WtRest,
    WtAxis,
    WtDiag
  } weight_e;

  // order: rest, E, N, W, S, NE, NW, SW, SE
  localparam logic signed [1:0] DirX [NumDir] =
    '{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd1};
  localparam logic signed [1:0] DirY [NumDir] =
    '{2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1};
  localparam weight_e DirWeight [NumDir] =
    '{WtRest, WtAxis, WtAxis, WtAxis, WtAxis, WtDiag, WtDiag, WtDiag, WtDiag};

  // values that travel alongside the arithmetic
  typedef struct packed {
    dist_vec_t f;
    word_t     dens;
    word_t     ux;
    word_t     uy;
  } carry_t;

  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [QuoW-1:0] quo;
    logic            ovf;
    logic            neg;
  } div_lane_t;

  typedef struct packed {
    div_lane_t       x;
    div_lane_t       y;
    logic [RhoW-1:0] d;
    logic            pos;
    carry_t          carry;
  } div_stage_t;

  typedef struct packed {
    logic [ProdW-1:0] xx;
    logic [ProdW-1:0] yy;
    logic [ProdW-1:0] pp;
    logic [ProdW-1:0] mm;
  } squares_t;

  function automatic word_t sat32(logic signed [SatInW-1:0] v);
    word_t r;
    if (v > SatInW'(WordMax)) begin
      r = WordMax;
    end else if (v < SatInW'(WordMin)) begin
      r = WordMin;
    end else begin
      r = v[WordW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/lbmc_vel_div.sv =====
// Pipelined restoring divider: momentum over density, one quotient bit per stage.
module lbmc_vel_div
  import lbmc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  div_stage_t in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output div_stage_t out_data_o
);

  logic       v_q  [DivSteps];
  div_stage_t st_q [DivSteps];
  logic       adv  [DivSteps];

  // step k: top step flags quotient overflow, the rest set quotient bit k
  function automatic div_lane_t div_step(div_lane_t l, logic [RhoW-1:0] d, int k);
    div_lane_t       o;
    logic [NumW-1:0] hi;
    o  = l;
    hi = l.rem >> k;
    if (hi >= NumW'(d)) begin
      o.rem = l.rem - (NumW'(d) << k);
      if (k == QuoW) begin
        o.ovf = 1'b1;
      end else begin
        o.quo = l.quo | (QuoW'(1) << k);
      end
    end
    return o;
  endfunction

  for (genvar s = 0; s < DivSteps; s++) begin : g_step
    div_stage_t src;
    div_stage_t nxt;
    logic       src_v;

    if (s == 0) begin : g_first
      assign src   = in_data_i;
      assign src_v = in_valid_i;
    end else begin : g_chain
      assign src   = st_q[s-1];
      assign src_v = v_q[s-1];
    end

    if (s == DivSteps - 1) begin : g_last
      assign adv[s] = !v_q[s] || !out_stall_i;
    end else begin : g_mid
      assign adv[s] = !v_q[s] || adv[s+1];
    end

    always_comb begin
      nxt   = src;
      nxt.x = div_step(src.x, src.d, QuoW - s);
      nxt.y = div_step(src.y, src.d, QuoW - s);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (adv[s]) begin
        v_q[s] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[s]) begin
        st_q[s] <= nxt;
      end
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = v_q[DivSteps-1];
  assign out_data_o  = st_q[DivSteps-1];

endmodule

// ===== hdl/lbm_d2q9_bgk_cell_update.sv =====
// D2Q9 BGK cell update: density, velocity, equilibrium and relaxation.
//
//  channel  | signals                              | carries
//  ---------+--------------------------------------+-------------------------------
//  input    | in_valid_i / in_stall_o              | f_*_i, nine distributions
//  output   | out_valid_o / out_stall_i            | post_*_o, density, velocity
//  config   | cfg_we_i / cfg_wdata_i               | relax_rate (unsigned Q1.30)
//
// One cell per cycle while the output is not stalled.
// The velocity passes through the 32-stage restoring divider.
// Reset clears the valid bits and loads the default relax rate.
// A stall holds only the stages that are full; empty stages keep filling.
module lbm_d2q9_bgk_cell_update
  import lbmc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [RelaxW-1:0]        cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [WordW-1:0]  f_rest_i,
  input  logic signed [WordW-1:0]  f_east_i,
  input  logic signed [WordW-1:0]  f_north_i,
  input  logic signed [WordW-1:0]  f_west_i,
  input  logic signed [WordW-1:0]  f_south_i,
  input  logic signed [WordW-1:0]  f_northeast_i,
  input  logic signed [WordW-1:0]  f_northwest_i,
  input  logic signed [WordW-1:0]  f_southwest_i,
  input  logic signed [WordW-1:0]  f_southeast_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [WordW-1:0]  post_rest_o,
  output logic signed [WordW-1:0]  post_east_o,
  output logic signed [WordW-1:0]  post_north_o,
  output logic signed [WordW-1:0]  post_west_o,
  output logic signed [WordW-1:0]  post_south_o,
  output logic signed [WordW-1:0]  post_northeast_o,
  output logic signed [WordW-1:0]  post_northwest_o,
  output logic signed [WordW-1:0]  post_southwest_o,
  output logic signed [WordW-1:0]  post_southeast_o,
  output logic signed [WordW-1:0]  cell_density_o,
  output logic signed [WordW-1:0]  velocity_x_o,
  output logic signed [WordW-1:0]  velocity_y_o
);

  logic [RelaxW-1:0] relax_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_rate_q <= RelaxReset;
    end else if (cfg_we_i) begin
      relax_rate_q <= cfg_wdata_i;
    end
  end

  // ---------------- valid bits and advance chain ----------------
  logic v0_q, v1_q, vu_q, vm_q, vp_q, ve_q, vw1_q, vw2_q, vw3_q, vr_q, vo_q;
  logic en0, en1, enu, enm, enp, ene, enw1, enw2, enw3, enr, eno;
  logic div_stall, div_valid;

  assign eno  = !vo_q  || !out_stall_i;
  assign enr  = !vr_q  || eno;
  assign enw3 = !vw3_q || enr;
  assign enw2 = !vw2_q || enw3;
  assign enw1 = !vw1_q || enw2;
  assign ene  = !ve_q  || enw1;
  assign enp  = !vp_q  || ene;
  assign enm  = !vm_q  || enp;
  assign enu  = !vu_q  || enm;
  assign en1  = !v1_q  || !div_stall;
  assign en0  = !v0_q  || en1;

  assign in_stall_o = !en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      vu_q  <= 1'b0;
      vm_q  <= 1'b0;
      vp_q  <= 1'b0;
      ve_q  <= 1'b0;
      vw1_q <= 1'b0;
      vw2_q <= 1'b0;
      vw3_q <= 1'b0;
      vr_q  <= 1'b0;
      vo_q  <= 1'b0;
    end else begin
      if (en0)  v0_q  <= in_valid_i;
      if (en1)  v1_q  <= v0_q;
      if (enu)  vu_q  <= div_valid;
      if (enm)  vm_q  <= vu_q;
      if (enp)  vp_q  <= vm_q;
      if (ene)  ve_q  <= vp_q;
      if (enw1) vw1_q <= ve_q;
      if (enw2) vw2_q <= vw1_q;
      if (enw3) vw3_q <= vw2_q;
      if (enr)  vr_q  <= vw3_q;
      if (eno)  vo_q  <= vr_q;
    end
  end

  // ---------------- stage 0: input register ----------------
  dist_vec_t f0_q;

  always_ff @(posedge clk_i) begin
    if (en0) begin
      f0_q[0] <= f_rest_i;
      f0_q[1] <= f_east_i;
      f0_q[2] <= f_north_i;
      f0_q[3] <= f_west_i;
      f0_q[4] <= f_south_i;
      f0_q[5] <= f_northeast_i;
      f0_q[6] <= f_northwest_i;
      f0_q[7] <= f_southwest_i;
      f0_q[8] <= f_southeast_i;
    end
  end

  // ---------------- stage 1: moments ----------------
  div_stage_t s1_d, s1_q;

  always_comb begin
    logic signed [SumW-1:0] rho, mx, my, fe, abs_x, abs_y;
    rho = '0;
    mx  = '0;
    my  = '0;
    for (int q = 0; q < NumDir; q++) begin
      fe  = SumW'($signed(f0_q[q]));
      rho = rho + fe;
      if (DirX[q] == 2'sd1) begin
        mx = mx + fe;
      end else if (DirX[q] == -2'sd1) begin
        mx = mx - fe;
      end
      if (DirY[q] == 2'sd1) begin
        my = my + fe;
      end else if (DirY[q] == -2'sd1) begin
        my = my - fe;
      end
    end
    abs_x = mx[SumW-1] ? -mx : mx;
    abs_y = my[SumW-1] ? -my : my;

    s1_d.x.rem = NumW'(abs_x[MagW-1:0]) << FracBits;
    s1_d.x.quo = '0;
    s1_d.x.ovf = 1'b0;
    s1_d.x.neg = mx[SumW-1];
    s1_d.y.rem = NumW'(abs_y[MagW-1:0]) << FracBits;
    s1_d.y.quo = '0;
    s1_d.y.ovf = 1'b0;
    s1_d.y.neg = my[SumW-1];
    s1_d.d     = rho[RhoW-1:0];
    s1_d.pos   = !rho[SumW-1] && (rho != '0);
    s1_d.carry.f    = f0_q;
    s1_d.carry.dens = sat32(SatInW'(rho));
    s1_d.carry.ux   = '0;
    s1_d.carry.uy   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q <= s1_d;
    end
  end

  // ---------------- divider ----------------
  div_stage_t div_out;

  lbmc_vel_div u_vel_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1_q),
    .in_stall_o  (div_stall),
    .in_data_i   (s1_q),
    .out_valid_o (div_valid),
    .out_stall_i (!enu),
    .out_data_o  (div_out)
  );

  // ---------------- stage U: velocity ----------------
  carry_t cu_d, cu_q;

  always_comb begin
    logic [WordW-1:0] mag_x, mag_y;
    mag_x = div_out.x.ovf ? VCap : {1'b0, div_out.x.quo};
    mag_y = div_out.y.ovf ? VCap : {1'b0, div_out.y.quo};
    cu_d  = div_out.carry;
    if (div_out.pos) begin
      cu_d.ux = div_out.x.neg ? -mag_x : mag_x;
      cu_d.uy = div_out.y.neg ? -mag_y : mag_y;
    end else begin
      cu_d.ux = '0;
      cu_d.uy = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enu) begin
      cu_q <= cu_d;
    end
  end

  // ---------------- stage M: squares ----------------
  carry_t   cm_q;
  squares_t sq_d, sq_q;

  always_comb begin
    logic signed [WordW:0] sum_p, sum_m, abs_p, abs_m;
    logic [WordW-1:0]      ax, ay;
    ax    = cu_q.ux[WordW-1] ? -cu_q.ux : cu_q.ux;
    ay    = cu_q.uy[WordW-1] ? -cu_q.uy : cu_q.uy;
    sum_p = (WordW+1)'($signed(cu_q.ux)) + (WordW+1)'($signed(cu_q.uy));
    sum_m = (WordW+1)'($signed(cu_q.ux)) - (WordW+1)'($signed(cu_q.uy));
    abs_p = sum_p[WordW] ? -sum_p : sum_p;
    abs_m = sum_m[WordW] ? -sum_m : sum_m;
    sq_d.xx = ProdW'(ax) * ProdW'(ax);
    sq_d.yy = ProdW'(ay) * ProdW'(ay);
    sq_d.pp = ProdW'(abs_p[WordW-1:0]) * ProdW'(abs_p[WordW-1:0]);
    sq_d.mm = ProdW'(abs_m[WordW-1:0]) * ProdW'(abs_m[WordW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (enm) begin
      cm_q <= cu_q;
      sq_q <= sq_d;
    end
  end

  // ---------------- stage P: polynomial per direction ----------------
  carry_t cp_q;
  word_t  p_d [NumDir];
  word_t  p_q [NumDir];

  always_comb begin
    logic [ProdW-1:0]      uu_full, sq_full;
    logic [SqW-1:0]        uu, sq;
    logic signed [CuW-1:0] uxe, uye, cu;
    logic signed [PW-1:0]  one, c3, s9, u3, p_full;
    uu_full = sq_q.xx + sq_q.yy;
    uu      = uu_full[ProdW-1:FracBits];
    uxe     = CuW'($signed(cm_q.ux));
    uye     = CuW'($signed(cm_q.uy));
    one     = PW'(1) << FracBits;
    u3      = ((PW'(uu) << 1) + PW'(uu)) >> 1;
    for (int q = 0; q < NumDir; q++) begin
      cu = '0;
      if (DirX[q] == 2'sd1) begin
        cu = cu + uxe;
      end else if (DirX[q] == -2'sd1) begin
        cu = cu - uxe;
      end
      if (DirY[q] == 2'sd1) begin
        cu = cu + uye;
      end else if (DirY[q] == -2'sd1) begin
        cu = cu - uye;
      end
      // (ux+uy)^2 serves both diagonals with equal signs, (ux-uy)^2 the others
      priority if (DirX[q] != 2'sd0 && DirY[q] != 2'sd0) begin
        sq_full = (DirX[q] == DirY[q]) ? sq_q.pp : sq_q.mm;
      end else if (DirX[q] != 2'sd0) begin
        sq_full = sq_q.xx;
      end else if (DirY[q] != 2'sd0) begin
        sq_full = sq_q.yy;
      end else begin
        sq_full = '0;
      end
      sq     = sq_full[ProdW-1:FracBits];
      c3     = (PW'(cu) <<< 1) + PW'(cu);
      s9     = ((PW'(sq) << 3) + PW'(sq)) >> 1;
      p_full = one + c3 + s9 - u3;
      p_d[q] = sat32(SatInW'(p_full));
    end
  end

  always_ff @(posedge clk_i) begin
    if (enp) begin
      cp_q <= cm_q;
      for (int q = 0; q < NumDir; q++) begin
        p_q[q] <= p_d[q];
      end
    end
  end

  // ---------------- stage E: density times polynomial ----------------
  carry_t                 ce_q;
  logic signed [ProdW-1:0] e_d [NumDir];
  logic signed [ProdW-1:0] e_q [NumDir];

  always_comb begin
    for (int q = 0; q < NumDir; q++) begin
      e_d[q] = ProdW'($signed(cp_q.dens)) * ProdW'($signed(p_q[q]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ene) begin
      ce_q <= cp_q;
      for (int q = 0; q < NumDir; q++) begin
        e_q[q] <= e_d[q];
      end
    end
  end

  // ---------------- stage W1: weight scaling, reciprocal partial products --------
  carry_t                  cw1_q;
  logic [YW-1:0]           y_d   [NumDir];
  logic [YW-1:0]           y1_q  [NumDir];
  logic                    neg_d [NumDir];
  logic                    neg1_q [NumDir];
  logic [LoW+RecipW-1:0]   pl_d  [NumDir];
  logic [LoW+RecipW-1:0]   pl_q  [NumDir];
  logic [HiW+RecipW-1:0]   ph_d  [NumDir];
  logic [HiW+RecipW-1:0]   ph_q  [NumDir];

  always_comb begin
    logic signed [TW-1:0] t;
    logic [TW-1:0]        m;
    for (int q = 0; q < NumDir; q++) begin
      t        = $signed(e_q[q][ProdW-1:FracBits]);
      neg_d[q] = t[TW-1];
      m        = t[TW-1] ? -t : t;
      // all weights reduce to a floor divide by nine of a scaled magnitude
      unique case (DirWeight[q])
        WtRest:  y_d[q] = {m, 2'b00};
        WtAxis:  y_d[q] = YW'(m);
        WtDiag:  y_d[q] = YW'(m >> 2);
        default: y_d[q] = YW'(m);
      endcase
      pl_d[q] = (LoW+RecipW)'(y_d[q][LoW-1:0]) * (LoW+RecipW)'(Recip);
      ph_d[q] = (HiW+RecipW)'(y_d[q][YW-1:LoW]) * (HiW+RecipW)'(Recip);
    end
  end

  always_ff @(posedge clk_i) begin
    if (enw1) begin
      cw1_q <= ce_q;
      for (int q = 0; q < NumDir; q++) begin
        y1_q[q]   <= y_d[q];
        neg1_q[q] <= neg_d[q];
        pl_q[q]   <= pl_d[q];
        ph_q[q]   <= ph_d[q];
      end
    end
  end

  // ---------------- stage W2: quotient estimate ----------------
  carry_t        cw2_q;
  logic [YW-1:0] y2_q   [NumDir];
  logic          neg2_q [NumDir];
  logic [QW-1:0] q0_d   [NumDir];
  logic [QW-1:0] q0_q   [NumDir];

  always_comb begin
    logic [AccW-1:0] acc;
    for (int q = 0; q < NumDir; q++) begin
      acc     = (AccW'(ph_q[q]) << LoW) + AccW'(pl_q[q]);
      q0_d[q] = acc[YW +: QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (enw2) begin
      cw2_q <= cw1_q;
      for (int q = 0; q < NumDir; q++) begin
        y2_q[q]   <= y1_q[q];
        neg2_q[q] <= neg1_q[q];
        q0_q[q]   <= q0_d[q];
      end
    end
  end

  // ---------------- stage W3: correction, sign, saturation ----------------
  carry_t cw3_q;
  word_t  feq_d [NumDir];
  word_t  feq_q [NumDir];

  always_comb begin
    logic [YW-1:0]            r;
    logic [QW-1:0]            qv;
    logic signed [SatInW-1:0] mag;
    for (int q = 0; q < NumDir; q++) begin
      // estimate is low by at most one
      r   = y2_q[q] - (YW'(q0_q[q]) << 3) - YW'(q0_q[q]);
      qv  = (r >= YW'(9)) ? q0_q[q] + QW'(1) : q0_q[q];
      mag = SatInW'(qv);
      feq_d[q] = sat32(neg2_q[q] ? -mag : mag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (enw3) begin
      cw3_q <= cw2_q;
      for (int q = 0; q < NumDir; q++) begin
        feq_q[q] <= feq_d[q];
      end
    end
  end

  // ---------------- stage R: relaxation product ----------------
  carry_t                     cr_q;
  logic signed [RelProdW-1:0] rp_d [NumDir];
  logic signed [RelProdW-1:0] rp_q [NumDir];

  always_comb begin
    logic signed [DiffW-1:0] diff;
    for (int q = 0; q < NumDir; q++) begin
      diff    = DiffW'($signed(feq_q[q])) - DiffW'($signed(cw3_q.f[q]));
      rp_d[q] = RelProdW'(diff) * RelProdW'($signed({1'b0, relax_rate_q}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (enr) begin
      cr_q <= cw3_q;
      for (int q = 0; q < NumDir; q++) begin
        rp_q[q] <= rp_d[q];
      end
    end
  end

  // ---------------- stage O: output register ----------------
  carry_t co_q;
  word_t  post_d [NumDir];
  word_t  post_q [NumDir];

  always_comb begin
    for (int q = 0; q < NumDir; q++) begin
      post_d[q] = sat32(SatInW'($signed(rp_q[q][RelProdW-1:RelaxFrac]))
                        + SatInW'($signed(cr_q.f[q])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (eno) begin
      co_q <= cr_q;
      for (int q = 0; q < NumDir; q++) begin
        post_q[q] <= post_d[q];
      end
    end
  end

  assign out_valid_o      = vo_q;
  assign post_rest_o      = post_q[0];
  assign post_east_o      = post_q[1];
  assign post_north_o     = post_q[2];
  assign post_west_o      = post_q[3];
  assign post_south_o     = post_q[4];
  assign post_northeast_o = post_q[5];
  assign post_northwest_o = post_q[6];
  assign post_southwest_o = post_q[7];
  assign post_southeast_o = post_q[8];
  assign cell_density_o   = co_q.dens;
  assign velocity_x_o     = co_q.ux;
  assign velocity_y_o     = co_q.uy;

endmodule

// ===== hdl/lbmc_checker.sv =====
// Port-level checks of the cell update, bound to the top level.
`include "lbm_d2q9_bgk_cell_update_assert.svh"

module lbmc_checker
  import lbmc_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [WordW-1:0] post_rest_o,
  input logic signed [WordW-1:0] cell_density_o,
  input logic signed [WordW-1:0] velocity_x_o,
  input logic signed [WordW-1:0] velocity_y_o
);

  `LBMC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  `LBMC_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(post_rest_o) && $stable(cell_density_o) && $stable(velocity_x_o), "result changed while stalled")

  // no positive density means no flow
  `LBMC_ASSERT_IMP(a_zero_vel, clk_i, rst_ni, out_valid_o && (cell_density_o[WordW-1] || cell_density_o == '0), velocity_x_o == '0 && velocity_y_o == '0, "velocity not zero at non-positive density")

  // velocity saturation is symmetric
  `LBMC_ASSERT_IMP(a_vel_sym, clk_i, rst_ni, out_valid_o, velocity_x_o != WordMin && velocity_y_o != WordMin, "velocity hit the negative limit")

endmodule

bind lbm_d2q9_bgk_cell_update lbmc_checker u_lbmc_checker (.*);

// ===== tb/sv/lbm_d2q9_bgk_cell_update_tb.sv =====
// Self-checking testbench for the D2Q9 BGK cell update pipeline.
module lbm_d2q9_bgk_cell_update_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lbmc_pkg::*;

  localparam int PipeDepth = 43;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    word_t [NumDir-1:0] f;
  } cell_t;

  typedef struct packed {
    word_t [NumDir-1:0] post;
    word_t dens;
    word_t ux;
    word_t uy;
  } update_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [RelaxW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  word_t f_in [NumDir];
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  word_t post_out [NumDir];
  word_t dens_o, ux_o, uy_o;

  cell_t cells_pending[$];
  update_t updates_due[$];
  logic [RelaxW-1:0] relax_model = RelaxReset;
  int mismatches = 0;
  int cycles = 0;
  bit in_took = 1'b0;
  bit quiet_idle = 1'b0;
  bit hold_feed = 1'b0;

  initial for (int i = 0; i < NumDir; i++) f_in[i] = '0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  lbm_d2q9_bgk_cell_update u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .f_rest_i(f_in[0]), .f_east_i(f_in[1]), .f_north_i(f_in[2]),
    .f_west_i(f_in[3]), .f_south_i(f_in[4]), .f_northeast_i(f_in[5]),
    .f_northwest_i(f_in[6]), .f_southwest_i(f_in[7]), .f_southeast_i(f_in[8]),
    .out_valid_o, .out_stall_i,
    .post_rest_o(post_out[0]), .post_east_o(post_out[1]),
    .post_north_o(post_out[2]), .post_west_o(post_out[3]),
    .post_south_o(post_out[4]), .post_northeast_o(post_out[5]),
    .post_northwest_o(post_out[6]), .post_southwest_o(post_out[7]),
    .post_southeast_o(post_out[8]), .cell_density_o(dens_o),
    .velocity_x_o(ux_o), .velocity_y_o(uy_o)
  );

  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // |m| << F / rho, truncated, capped at 2^31-1, sign of m
  function automatic longint speed_quot(longint m, longint rho);
    longint unsigned a, d, q, r;
    a = (m < 0) ? -m : m;
    d = rho;
    q = a / d;
    r = a % d;
    for (int i = 0; i < FracBits && q <= 64'h7FFF_FFFF; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return (m < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic update_t bgk_collide(cell_t c);
    update_t u;
    longint rho, mx, my, dens, vx, vy, cu, p, feq, diff, pr, num, den;
    longint unsigned uu, mag, sq;
    rho = 0; mx = 0; my = 0; vx = 0; vy = 0;
    for (int q = 0; q < NumDir; q++) begin
      rho += longint'(c.f[q]);
      mx += longint'(DirX[q]) * longint'(c.f[q]);
      my += longint'(DirY[q]) * longint'(c.f[q]);
    end
    dens = clamp_word(rho);
    if (rho > 0) begin
      vx = speed_quot(mx, rho);
      vy = speed_quot(my, rho);
    end
    uu = (longint'(vx * vx) + longint'(vy * vy)) >> FracBits;
    for (int q = 0; q < NumDir; q++) begin
      cu = longint'(DirX[q]) * vx + longint'(DirY[q]) * vy;
      mag = (cu < 0) ? -cu : cu;
      sq = (mag * mag) >> FracBits;
      p = (64'sd1 << FracBits) + 3 * cu + longint'((9 * sq) >> 1)
          - longint'((3 * uu) >> 1);
      p = clamp_word(p);
      num = (DirWeight[q] == WtRest) ? 4 : 1;
      den = (DirWeight[q] == WtDiag) ? 36 : 9;
      feq = clamp_word(((dens * p) >>> FracBits) * num / den);
      diff = feq - longint'(c.f[q]);
      pr = clamp_word(longint'(c.f[q]) + ((diff * longint'({1'b0, relax_model})) >>> 30));
      u.post[q] = word_t'(pr);
    end
    u.dens = word_t'(dens);
    u.ux = word_t'(vx);
    u.uy = word_t'(vy);
    return u;
  endfunction

  function automatic bit idle_now();
    return !quiet_idle && ($urandom_range(99) < 7);
  endfunction

  // driver: valid held until a transfer, payload stable while stalled
  always @(negedge clk_i) begin
    cell_t c;
    if (rst_ni) begin
      if (in_took) begin
        // transfer happened at the last rising edge
        updates_due.push_back(bgk_collide(cells_pending.pop_front()));
      end
      if (!in_valid_i || in_took) begin
        if (cells_pending.size() > 0 && !hold_feed && !idle_now()) begin
          c = cells_pending[0];
          for (int i = 0; i < NumDir; i++) f_in[i] <= c.f[i];
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= idle_now();
    end
  end

  // monitor
  always @(posedge clk_i) begin
    update_t exp_u, got;
    cycles <= cycles + 1;
    in_took <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      for (int i = 0; i < NumDir; i++) got.post[i] = post_out[i];
      got.dens = dens_o;
      got.ux = ux_o;
      got.uy = uy_o;
      if (updates_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transfer: %h", got);
      end else begin
        exp_u = updates_due.pop_front();
        if (exp_u != got) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected %h", exp_u);
            $display("          actual   %h", got);
          end
        end
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) @(posedge clk_i);
    $display("lbm_d2q9_bgk_cell_update test failed");
    $finish;
  end

  task automatic add_cell(word_t a0, a1, a2, a3, a4, a5, a6, a7, a8);
    cell_t c;
    c.f[0] = a0; c.f[1] = a1; c.f[2] = a2; c.f[3] = a3; c.f[4] = a4;
    c.f[5] = a5; c.f[6] = a6; c.f[7] = a7; c.f[8] = a8;
    cells_pending.push_back(c);
  endtask

  function automatic word_t rand_dist();
    case ($urandom_range(5))
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(32'h0100_0000));
      2: return $urandom_range(1) ? WordMax : WordMin;
      default: return word_t'(32'h0100_0000 + $urandom_range(32'h0040_0000) - 32'h0020_0000);
    endcase
  endfunction

  task automatic add_random(int n);
    word_t v [NumDir];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < NumDir; i++) v[i] = rand_dist();
      add_cell(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
    end
  endtask

  task automatic drain();
    while (cells_pending.size() > 0 || updates_due.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (PipeDepth + 5) @(posedge clk_i);
  endtask

  task automatic set_relax(logic [RelaxW-1:0] r);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= r;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    relax_model = r;
  endtask

  initial begin
    word_t q = 32'sh0100_0000;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: zero, rest, flows, non-positive and huge density, overflow
    add_cell(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_cell(q * 4, q, q, q, q, q / 4, q / 4, q / 4, q / 4);
    add_cell(q, q * 2, q, 0, q, q, 0, 0, q);
    add_cell(q, 0, q * 2, q, 0, q, q, 0, 0);
    add_cell(-q, 0, 0, 0, 0, 0, 0, 0, 0);
    add_cell(q, WordMin, 0, 0, 0, 0, 0, 0, 0);
    add_cell(WordMax, WordMax, WordMax, WordMax, WordMax, WordMax, WordMax,
             WordMax, WordMax);
    add_cell(WordMin, WordMin, WordMin, WordMin, WordMin, WordMin, WordMin,
             WordMin, WordMin);
    add_cell(1, WordMax, 0, WordMin + 2, 0, 0, 0, 0, 0);
    add_cell(1, 0, WordMax, 0, WordMin + 2, 0, 0, 0, 0);
    add_cell(0, 1, 0, 0, 0, 0, 0, 0, 0);
    add_cell(-1, -1, -1, -1, -1, -1, -1, -1, -1);
    add_cell(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
             32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
             32'sh5555_5555);
    add_random(100);
    drain();
    set_relax('0);
    add_random(100);
    drain();
    set_relax({RelaxW{1'b1}});
    add_random(100);
    drain();
    set_relax(31'h4000_0000);
    quiet_idle = 1'b1;
    add_random(150);
    drain();
    quiet_idle = 1'b0;
    set_relax(RelaxW'($urandom));
    add_random(120);
    // sender holds off until everything is out
    while (cells_pending.size() > 60) @(posedge clk_i);
    hold_feed = 1'b1;
    while (updates_due.size() > 0 || in_valid_i) @(posedge clk_i);
    hold_feed = 1'b0;
    add_random(120);
    drain();
    if (mismatches == 0) begin
      $display("lbm_d2q9_bgk_cell_update test passed");
    end else begin
      $display("lbm_d2q9_bgk_cell_update test failed");
    end
    $finish;
  end

endmodule
